>>> rtl/plic_pkg.sv
// Shared constants and types of the platform interrupt controller.
package plic_pkg;
  localparam int NUM_SOURCES = 64;
  localparam int NUM_HARTS   = 2;
  localparam int PRIO_W      = 32;
  localparam int NUM_CTX     = 2 * NUM_HARTS;
  localparam int SRC_W       = $clog2(NUM_SOURCES);
  localparam int CNT_W       = SRC_W + 1;
  localparam int CTX_W       = $clog2(NUM_CTX);
  localparam int SRC_WORDS   = (NUM_SOURCES + 31) / 32;
  localparam int WORD_W      = (SRC_WORDS > 1) ? $clog2(SRC_WORDS) : 1;

  localparam logic [25:0] OFF_PEND     = 26'h0001000;
  localparam logic [25:0] OFF_PEND_END = 26'h0001080;
  localparam logic [25:0] OFF_EN       = 26'h0002000;
  localparam logic [25:0] OFF_EN_END   = 26'h01F2000;
  localparam logic [25:0] OFF_CTX      = 26'h0200000;
  localparam logic [9:0]  FLAG_THR     = 10'h000;
  localparam logic [9:0]  FLAG_CLAIM   = 10'h001;

  localparam logic [2:0] MODE_READ  = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_EDGE  = 3'd2;
  localparam logic [2:0] MODE_RAISE = 3'd3;
  localparam logic [2:0] MODE_LOWER = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_RDP   = 6'b000100,
    S_CLAIM = 6'b001000,
    S_LINES = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;
endpackage

>>> rtl/plic_ram.sv
// Generic single-port RAM with registered read data.
module plic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/platform_interrupt_controller.sv
// Top level of the platform interrupt controller: decode, state and scan sequencer.
//
// Usage: one input channel carries transactions (bus read, bus write, edge send,
// level raise, level lower) with valid/stall handshake; one output channel returns
// exactly one result per transaction: read data, accepted flag and the four
// context interrupt lines as they stand after the transaction.
// A transaction is decoded in the S_EXEC state; a priority read adds the S_RDP
// state for the priority RAM. Lines are then recomputed by walking all sources
// through one shared compare unit, one source per cycle, for each context in turn.
// A claim read first walks the sources of its own context once more to pick the
// winner.
// The block takes one transaction at a time; in_stall is high from acceptance
// until the result has been taken. While out_stall is high the result holds.
// Reset (synchronous, rst_n low) clears pending, level, enable and threshold
// state and the priority valid bits, so every priority reads as zero.
module platform_interrupt_controller
  import plic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [25:0] in_bus_offset,
  input  logic [31:0] in_write_data,
  input  logic [5:0]  in_source_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_accepted,
  output logic [3:0]  out_context_lines
);
  state_t state_r;

  // Latched transaction.
  logic [2:0]  mode_r;
  logic [25:0] off_r;
  logic [31:0] data_r;
  logic [5:0]  src_r;

  // Controller state.
  logic [PRIO_W-1:0]      thr_r [NUM_CTX];
  logic [NUM_SOURCES-1:0] en_r  [NUM_CTX];
  logic [NUM_SOURCES-1:0] pend_r, level_r, pvalid_r;

  // Result registers.
  logic [31:0] rdata_r;
  logic        acc_r;
  logic [3:0]  lines_r;

  // Scan sequencer.
  logic [CNT_W-1:0]  cnt_r;
  logic [SRC_W-1:0]  cmp_id_r;
  logic              cmp_v_r;
  logic [CTX_W-1:0]  ctx_r;
  logic [SRC_W-1:0]  best_r;
  logic [PRIO_W-1:0] best_prio_r;
  logic              line_r;
  logic [SRC_W-1:0]  rd_id_r;
  logic              rd_ok_r;

  // Priority RAM.
  logic              ram_we;
  logic [SRC_W-1:0]  ram_addr;
  logic [PRIO_W-1:0] ram_q;

  plic_ram #(.WIDTH(PRIO_W), .DEPTH(NUM_SOURCES)) u_prio_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(data_r[PRIO_W-1:0]),
    .rdata(ram_q)
  );

  // Address decode of the latched offset.
  logic [25:0] en_rel, ctx_rel;
  logic        in_prio, in_pend, in_en, in_ctx;
  logic        prio_ok, pend_ok, en_ok, ctx_ok;
  logic [9:0]  prio_id, flag;
  logic [WORD_W-1:0] pend_w, en_w;
  logic [CTX_W-1:0]  en_ctx, cx_ctx;
  logic        scanning;

  always_comb begin
    en_rel  = off_r - OFF_EN;
    ctx_rel = off_r - OFF_CTX;
    in_prio = off_r < OFF_PEND;
    in_pend = (off_r >= OFF_PEND) && (off_r < OFF_PEND_END);
    in_en   = (off_r >= OFF_EN) && (off_r < OFF_EN_END);
    in_ctx  = off_r >= OFF_CTX;
    prio_id = off_r[11:2];
    prio_ok = in_prio && (prio_id != '0) && (32'(prio_id) < NUM_SOURCES);
    pend_ok = in_pend && (32'(off_r[6:2]) < SRC_WORDS);
    pend_w  = off_r[WORD_W+1:2];
    en_w    = en_rel[WORD_W+1:2];
    en_ok   = in_en && (32'(en_rel[6:2]) < SRC_WORDS) && (32'(en_rel[25:7]) < NUM_CTX);
    en_ctx  = en_rel[CTX_W+6:7];
    flag    = ctx_rel[11:2];
    ctx_ok  = in_ctx && (32'(ctx_rel[25:12]) < NUM_CTX);
    cx_ctx  = ctx_rel[CTX_W+11:12];
    scanning = (state_r == S_CLAIM) || (state_r == S_LINES);
    ram_we  = (state_r == S_EXEC) && (mode_r == MODE_WRITE) && prio_ok;
    ram_addr = scanning ? cnt_r[SRC_W-1:0] : prio_id[SRC_W-1:0];
  end

  // Shared compare unit: one source per cycle against the running best and threshold.
  logic [PRIO_W-1:0] eff_prio;
  logic              elig, take;
  logic [SRC_W-1:0]  best_nxt;
  logic              line_nxt;
  logic              scan_end;

  always_comb begin
    eff_prio = pvalid_r[cmp_id_r] ? ram_q : '0;
    elig     = cmp_v_r && pend_r[cmp_id_r] && en_r[ctx_r][cmp_id_r];
    take     = elig && (eff_prio > best_prio_r);
    best_nxt = take ? cmp_id_r : best_r;
    line_nxt = line_r || (elig && (eff_prio > thr_r[ctx_r]));
    scan_end = cnt_r == CNT_W'(NUM_SOURCES);
  end

  assign in_stall          = state_r != S_IDLE;
  assign out_valid         = state_r == S_OUT;
  assign out_read_data     = rdata_r;
  assign out_accepted      = acc_r;
  assign out_context_lines = lines_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_r   <= '0;
      level_r  <= '0;
      pvalid_r <= '0;
      cnt_r    <= '0;
      cmp_v_r  <= 1'b0;
      for (int c = 0; c < NUM_CTX; c++) begin
        thr_r[c] <= '0;
        en_r[c]  <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            off_r   <= {in_bus_offset[25:2], 2'b00};
            data_r  <= in_write_data;
            src_r   <= in_source_id;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          rdata_r     <= '0;
          acc_r       <= 1'b1;
          cnt_r       <= '0;
          cmp_v_r     <= 1'b0;
          best_r      <= '0;
          best_prio_r <= '0;
          line_r      <= 1'b0;
          ctx_r       <= '0;
          state_r     <= S_LINES;
          case (mode_r)
            MODE_READ: begin
              if (prio_ok) begin
                rd_id_r <= prio_id[SRC_W-1:0];
                rd_ok_r <= 1'b1;
                state_r <= S_RDP;
              end else if (pend_ok) begin
                rdata_r <= pend_r[pend_w*32 +: 32];
              end else if (en_ok) begin
                rdata_r <= en_r[en_ctx][en_w*32 +: 32];
              end else if (ctx_ok && flag == FLAG_THR) begin
                rdata_r <= 32'(thr_r[cx_ctx]);
              end else if (ctx_ok && flag == FLAG_CLAIM) begin
                ctx_r   <= cx_ctx;
                state_r <= S_CLAIM;
              end
            end
            MODE_WRITE: begin
              if (prio_ok) begin
                pvalid_r[prio_id[SRC_W-1:0]] <= 1'b1;
              end else if (en_ok) begin
                en_r[en_ctx][en_w*32 +: 32] <= data_r;
              end else if (ctx_ok && flag == FLAG_THR) begin
                thr_r[cx_ctx] <= data_r[PRIO_W-1:0];
              end else if (ctx_ok && flag == FLAG_CLAIM) begin
                if (data_r != '0 && data_r < 32'(NUM_SOURCES)
                    && level_r[data_r[SRC_W-1:0]]) begin
                  pend_r[data_r[SRC_W-1:0]] <= 1'b1;
                end
              end
            end
            MODE_EDGE, MODE_RAISE, MODE_LOWER: begin
              if (src_r == '0 || 32'(src_r) >= NUM_SOURCES) begin
                acc_r <= 1'b0;
              end else if (mode_r == MODE_EDGE) begin
                pend_r[src_r[SRC_W-1:0]] <= 1'b1;
              end else if (mode_r == MODE_RAISE) begin
                if (!level_r[src_r[SRC_W-1:0]]) begin
                  level_r[src_r[SRC_W-1:0]] <= 1'b1;
                  pend_r[src_r[SRC_W-1:0]]  <= 1'b1;
                end
              end else begin
                level_r[src_r[SRC_W-1:0]] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        S_RDP: begin
          // Priority RAM data is valid now.
          rdata_r <= (rd_ok_r && pvalid_r[rd_id_r]) ? 32'(ram_q) : '0;
          state_r <= S_LINES;
        end
        S_CLAIM, S_LINES: begin
          cnt_r       <= cnt_r + 1'b1;
          cmp_id_r    <= cnt_r[SRC_W-1:0];
          cmp_v_r     <= !scan_end;
          best_r      <= best_nxt;
          best_prio_r <= take ? eff_prio : best_prio_r;
          line_r      <= line_nxt;
          if (scan_end) begin
            // Restart the walk: after a claim with context 0, else with the next context, if any.
            cnt_r       <= '0;
            cmp_v_r     <= 1'b0;
            best_r      <= '0;
            best_prio_r <= '0;
            line_r      <= 1'b0;
            if (state_r == S_CLAIM) begin
              rdata_r <= 32'(best_nxt);
              if (best_nxt != '0) begin
                pend_r[best_nxt] <= 1'b0;
              end
              ctx_r   <= '0;
              state_r <= S_LINES;
            end else begin
              lines_r[ctx_r] <= line_nxt;
              if (ctx_r == CTX_W'(NUM_CTX - 1)) begin
                state_r <= S_OUT;
              end else begin
                ctx_r <= ctx_r + 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
